@@ design/sfc_pkg.sv @@
// sfc_pkg: shared types and constants for the sliding frame checker.
// Holds byte and register-index types, operation and register codes, reset values
// and the sequencer state type. No dependencies.
package sfc_pkg;

   localparam int BYTE_W      = 8;
   localparam int CSR_INDEX_W = 8;

   typedef logic [BYTE_W-1:0]      byte_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   // Operation codes carried on the request channel
   localparam logic OP_RECEIVE = 1'b0;
   localparam logic OP_READ    = 1'b1;

   // Configuration register indexes
   localparam csr_index_type CSR_FRAME_MARKER = 8'd0;
   localparam csr_index_type CSR_TAG_BYTE     = 8'd1;

   // Register reset values
   localparam byte_type MARKER_RESET = 8'hFF;
   localparam byte_type TAG_RESET    = 8'h4D;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_HDR0,
      ST_HDR1,
      ST_HDR2,
      ST_HDR3,
      ST_COPY,
      ST_DRAIN,
      ST_FINISH
   } sfc_state_type;

endpackage

@@ design/sfc_if.sv @@
// sfc_if: valid/ready channel interfaces for the sliding frame checker.
// Request, response and configuration channels; depends on sfc_pkg.

// Request channel: one beat is a received byte or a record read
interface sfc_req_if import sfc_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     operation;
   byte_type rx_byte;
   byte_type read_index;

   modport source (output valid, output operation, output rx_byte, output read_index,
                   input ready);
   modport sink   (input valid, input operation, input rx_byte, input read_index,
                   output ready);
endinterface

// Response channel: one beat per request beat
interface sfc_rsp_if import sfc_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     header_match;
   logic     frame_good;
   byte_type read_byte;

   modport source (output valid, output header_match, output frame_good,
                   output read_byte, input ready);
   modport sink   (input valid, input header_match, input frame_good,
                   input read_byte, output ready);
endinterface

// Configuration write channel
interface sfc_csr_if import sfc_pkg::*; ();
   logic          valid;
   logic          ready;
   csr_index_type index;
   byte_type      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/sfc_mem.sv @@
// sfc_mem: single-port-write, single-port-read byte memory with registered read data.
// Per-entry valid bits make never-written entries read as zero; depends on sfc_pkg.
module sfc_mem import sfc_pkg::*; #(
   parameter int DEPTH = 146,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  byte_type      wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output byte_type      rd_data
);

   byte_type   store_ff [DEPTH];
   logic       valid_ff [DEPTH];
   byte_type   rd_data_ff;

   // Write the data array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Clear valid bits on reset, mark entries as they are written
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Register read data; unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? store_ff[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/sliding_frame_checker_unit.sv @@
// sliding_frame_checker_unit: byte ring with header check, record copy and XOR/sum check.
// Receive beat: on a header match the sequencer copies window positions 2 onward into
// the record store before the next accept, on a miss it stops after the header reads.
// The walk over the ring through its single read port sets the pace of a receive.
// Synchronous active-high reset clears the write pointer, sequencer and memory valid
// bits; registers go to 255 and 77. Depends on sfc_pkg, sfc_if and sfc_mem.
module sliding_frame_checker_unit import sfc_pkg::*; #(
   parameter int RECORD_LENGTH = 146
) (
   input  logic      clock,
   input  logic      reset,
   sfc_req_if.sink   req_chan,
   sfc_rsp_if.source rsp_chan,
   sfc_csr_if.sink   csr_chan
);

   localparam int AW = $clog2(RECORD_LENGTH);
   localparam logic [AW:0]     LEN_W     = (AW+1)'(RECORD_LENGTH);
   localparam logic [BYTE_W:0] LEN_IDX   = (BYTE_W+1)'(RECORD_LENGTH);
   localparam logic [AW-1:0]   POS_ZERO  = AW'(0);
   localparam logic [AW-1:0]   POS_FIRST = AW'(2);
   localparam logic [AW-1:0]   POS_TAG   = AW'(4);
   localparam logic [AW-1:0]   POS_XCHK  = AW'(RECORD_LENGTH - 4);
   localparam logic [AW-1:0]   POS_SCHK  = AW'(RECORD_LENGTH - 3);
   localparam logic [AW-1:0]   POS_TRAIL = AW'(RECORD_LENGTH - 2);
   localparam logic [AW-1:0]   POS_LAST  = AW'(RECORD_LENGTH - 1);

   sfc_state_type state_ff, state_in;

   byte_type      marker_ff, tag_ff;
   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] dpos_ff, dpos_in;
   logic          dvalid_ff, dvalid_in;
   logic          hdr_ok_ff, hdr_ok_in;
   logic          idx_ok_ff, idx_ok_in;
   byte_type      xor_ff, xor_in;
   byte_type      sum_ff, sum_in;
   byte_type      xchk_ff, xchk_in;
   byte_type      schk_ff, schk_in;
   logic          pend_match_ff, pend_match_in;
   logic          pend_good_ff, pend_good_in;
   byte_type      pend_byte_ff, pend_byte_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_match_ff, rsp_match_in;
   logic          rsp_good_ff, rsp_good_in;
   byte_type      rsp_byte_ff, rsp_byte_in;

   logic          req_beat;
   logic          rsp_free;
   logic          hdr_last_ok;

   logic          ring_we, ring_re;
   logic [AW-1:0] ring_raddr;
   logic [AW-1:0] pos_sel;
   logic [AW:0]   pos_sum;
   byte_type      ring_rdata;

   logic          store_we, store_re;
   logic [AW-1:0] store_raddr;
   byte_type      store_rdata;

   assign req_beat    = req_chan.valid && req_chan.ready;
   assign rsp_free    = !rsp_valid_ff || rsp_chan.ready;
   assign hdr_last_ok = hdr_ok_ff && (ring_rdata == marker_ff);

   // Configuration registers, always ready
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= MARKER_RESET;
         tag_ff    <= TAG_RESET;
      end else if (csr_chan.valid) begin
         if (csr_chan.index == CSR_FRAME_MARKER) begin
            marker_ff <= csr_chan.data;
         end else if (csr_chan.index == CSR_TAG_BYTE) begin
            tag_ff <= csr_chan.data;
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               state_in = (req_chan.operation == OP_READ) ? ST_RD_WAIT : ST_HDR0;
            end
         end
         ST_RD_WAIT: state_in = ST_FINISH;
         ST_HDR0:    state_in = ST_HDR1;
         ST_HDR1:    state_in = ST_HDR2;
         ST_HDR2:    state_in = ST_HDR3;
         ST_HDR3:    state_in = hdr_last_ok ? ST_COPY : ST_FINISH;
         ST_COPY: begin
            if (pos_ff == POS_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:   state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshake and memory controls
   always_comb begin
      req_chan.ready = 1'b0;
      ring_we        = 1'b0;
      ring_re        = 1'b0;
      store_re       = 1'b0;
      pos_sel        = POS_ZERO;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            ring_we        = req_chan.valid && (req_chan.operation == OP_RECEIVE);
            store_re       = req_chan.valid && (req_chan.operation == OP_READ);
         end
         ST_HDR0: begin
            ring_re = 1'b1;
            pos_sel = POS_ZERO;
         end
         ST_HDR1: begin
            ring_re = 1'b1;
            pos_sel = POS_TAG;
         end
         ST_HDR2: begin
            ring_re = 1'b1;
            pos_sel = POS_TRAIL;
         end
         ST_COPY: begin
            ring_re = 1'b1;
            pos_sel = pos_ff;
         end
         default: begin
         end
      endcase
   end

   // Map window position to ring address; oldest byte sits at the write pointer
   always_comb begin
      pos_sum    = {1'b0, wp_ff} + {1'b0, pos_sel};
      ring_raddr = (pos_sum >= LEN_W) ? AW'(pos_sum - LEN_W) : pos_sum[AW-1:0];
   end

   assign store_raddr = req_chan.read_index[AW-1:0];
   assign store_we    = dvalid_ff;

   // Datapath next values
   always_comb begin
      wp_in         = wp_ff;
      pos_in        = pos_ff;
      dpos_in       = pos_ff;
      dvalid_in     = (state_ff == ST_COPY);
      hdr_ok_in     = hdr_ok_ff;
      idx_ok_in     = idx_ok_ff;
      xor_in        = xor_ff;
      sum_in        = sum_ff;
      xchk_in       = xchk_ff;
      schk_in       = schk_ff;
      pend_match_in = pend_match_ff;
      pend_good_in  = pend_good_ff;
      pend_byte_in  = pend_byte_ff;

      // Advance the write pointer on a received byte
      if (ring_we) begin
         wp_in = (wp_ff == POS_LAST) ? POS_ZERO : wp_ff + AW'(1);
      end
      if (store_re) begin
         idx_ok_in = ({1'b0, req_chan.read_index} < LEN_IDX);
      end

      unique case (state_ff)
         ST_RD_WAIT: begin
            pend_match_in = 1'b0;
            pend_good_in  = 1'b0;
            pend_byte_in  = idx_ok_ff ? store_rdata : '0;
         end
         ST_HDR1: hdr_ok_in = (ring_rdata == marker_ff);
         ST_HDR2: hdr_ok_in = hdr_ok_ff && (ring_rdata == tag_ff);
         ST_HDR3: begin
            pend_match_in = hdr_last_ok;
            pend_good_in  = 1'b0;
            pend_byte_in  = '0;
            pos_in        = POS_FIRST;
            xor_in        = '0;
            sum_in        = '0;
         end
         ST_COPY: pos_in = pos_ff + AW'(1);
         ST_DRAIN: begin
            pend_good_in = (xor_ff == xchk_ff) && (sum_ff == schk_ff);
         end
         default: begin
         end
      endcase

      // Fold returning window bytes into the checks
      if (dvalid_ff) begin
         if (dpos_ff < POS_XCHK) begin
            xor_in = xor_ff ^ ring_rdata;
            sum_in = sum_ff + ring_rdata;
         end
         if (dpos_ff == POS_XCHK) begin
            xchk_in = ring_rdata;
         end
         if (dpos_ff == POS_SCHK) begin
            schk_in = ring_rdata;
         end
      end
   end

   // Response register: load in FINISH, drop on a taken beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_match_in = rsp_match_ff;
      rsp_good_in  = rsp_good_ff;
      rsp_byte_in  = rsp_byte_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_FINISH) && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_match_in = pend_match_ff;
         rsp_good_in  = pend_good_ff;
         rsp_byte_in  = pend_byte_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         dvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         dvalid_ff    <= dvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      dpos_ff       <= dpos_in;
      hdr_ok_ff     <= hdr_ok_in;
      idx_ok_ff     <= idx_ok_in;
      xor_ff        <= xor_in;
      sum_ff        <= sum_in;
      xchk_ff       <= xchk_in;
      schk_ff       <= schk_in;
      pend_match_ff <= pend_match_in;
      pend_good_ff  <= pend_good_in;
      pend_byte_ff  <= pend_byte_in;
      rsp_match_ff  <= rsp_match_in;
      rsp_good_ff   <= rsp_good_in;
      rsp_byte_ff   <= rsp_byte_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.header_match = rsp_match_ff;
   assign rsp_chan.frame_good   = rsp_good_ff;
   assign rsp_chan.read_byte    = rsp_byte_ff;

   // Receive ring: written once per received byte, walked by the sequencer
   sfc_mem #(
      .DEPTH (RECORD_LENGTH),
      .AW    (AW)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ring_we),
      .wr_addr (wp_ff),
      .wr_data (req_chan.rx_byte),
      .rd_en   (ring_re),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   // Record store: filled from ring read data during the copy walk
   sfc_mem #(
      .DEPTH (RECORD_LENGTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (store_we),
      .wr_addr (dpos_ff),
      .wr_data (ring_rdata),
      .rd_en   (store_re),
      .rd_addr (store_raddr),
      .rd_data (store_rdata)
   );

endmodule

@@ sim/tb.sv @@
// tb: self-checking testbench for sliding_frame_checker_unit.
// Drives request and register beats, predicts every response in a scoreboard class and
// compares field by field. Depends on sfc_pkg, sfc_if and the unit under test.
module tb;
   import sfc_pkg::*;

   localparam int RECORD_LENGTH   = 146;
   localparam int CYCLE_LIMIT     = 1_500_000;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int HOLD_OFF_START  = 500;
   localparam int QUIET_FIRST     = 900;
   localparam int QUIET_LAST      = 1150;
   localparam int PHASE_ITEMS     = 180;
   localparam int PHASE_COUNT     = 6;
   localparam int IDLE_PERCENT    = 6;
   localparam int REPORT_LIMIT    = 10;

   // Register indexes that map to nothing
   localparam csr_index_type CSR_UNMAPPED_LOW = 8'd2;
   localparam csr_index_type CSR_UNMAPPED_TOP = 8'hFF;

   typedef struct packed {
      logic     header_match;
      logic     frame_good;
      byte_type read_byte;
   } frame_outcome_type;

   // Byte history, record copy and register values mirrored from the unit
   class frame_scoreboard;
      byte_type          rx_history[RECORD_LENGTH];
      byte_type          record_copy[RECORD_LENGTH];
      int unsigned       window_base;
      int unsigned       next_slot;
      byte_type          marker_value;
      byte_type          tag_value;
      frame_outcome_type pending_outcomes[$];
      int unsigned       error_count;
      int unsigned       mismatch_reports;

      function new();
         foreach (rx_history[i]) begin
            rx_history[i]  = '0;
            record_copy[i] = '0;
         end
         window_base      = 0;
         next_slot        = 0;
         marker_value     = MARKER_RESET;
         tag_value        = TAG_RESET;
         error_count      = 0;
         mismatch_reports = 0;
      endfunction

      function byte_type window_byte(int unsigned pos);
         return rx_history[(window_base + pos) % RECORD_LENGTH];
      endfunction

      function void note_register_write(csr_index_type index, byte_type data);
         if (index == CSR_FRAME_MARKER) begin
            marker_value = data;
         end else if (index == CSR_TAG_BYTE) begin
            tag_value = data;
         end
      endfunction

      // Advance the window on a receive, copy the record on a header hit, or read the copy
      function frame_outcome_type frame_check_outcome(logic op, byte_type rx, byte_type idx);
         frame_outcome_type res;
         byte_type          xor_sum;
         byte_type          add_sum;
         byte_type          b;
         int                p;
         res = '0;
         if (op == OP_READ) begin
            if (idx < RECORD_LENGTH) res.read_byte = record_copy[idx];
         end else begin
            if (window_base == next_slot) window_base = (window_base + 1) % RECORD_LENGTH;
            rx_history[next_slot] = rx;
            next_slot = (next_slot + 1) % RECORD_LENGTH;
            if (window_byte(0) == marker_value && window_byte(4) == tag_value &&
                window_byte(RECORD_LENGTH - 2) == marker_value) begin
               res.header_match = 1'b1;
               xor_sum = '0;
               add_sum = '0;
               for (p = 2; p < RECORD_LENGTH; p++) begin
                  b = window_byte(p);
                  record_copy[p] = b;
                  if (p < RECORD_LENGTH - 4) begin
                     xor_sum = xor_sum ^ b;
                     add_sum = add_sum + b;
                  end
               end
               res.frame_good = (window_byte(RECORD_LENGTH - 4) == xor_sum) &&
                                (window_byte(RECORD_LENGTH - 3) == add_sum);
            end
         end
         return res;
      endfunction

      function void note_request(logic op, byte_type rx, byte_type idx);
         pending_outcomes.push_back(frame_check_outcome(op, rx, idx));
      endfunction

      function void check_response(logic header_match, logic frame_good, byte_type read_byte);
         frame_outcome_type want;
         if (pending_outcomes.size() == 0) begin
            error_count++;
            if (mismatch_reports < REPORT_LIMIT) begin
               mismatch_reports++;
               $display("unexpected response: match=%0b good=%0b byte=%02h",
                        header_match, frame_good, read_byte);
            end
            return;
         end
         want = pending_outcomes.pop_front();
         if (want.header_match !== header_match || want.frame_good !== frame_good ||
             want.read_byte !== read_byte) begin
            error_count++;
            if (mismatch_reports < REPORT_LIMIT) begin
               mismatch_reports++;
               $display("mismatch: exp m=%0b g=%0b b=%02h, got m=%0b g=%0b b=%02h",
                        want.header_match, want.frame_good, want.read_byte,
                        header_match, frame_good, read_byte);
            end
         end
      endfunction

      function int pending_count();
         return pending_outcomes.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   sfc_req_if req_bus ();
   sfc_rsp_if rsp_bus ();
   sfc_csr_if csr_bus ();

   sliding_frame_checker_unit #(.RECORD_LENGTH(RECORD_LENGTH)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   frame_scoreboard outcome_board;
   int unsigned     accepted_requests = 0;
   int unsigned     cycle_count = 0;
   byte_type        current_marker = MARKER_RESET;
   byte_type        current_tag = TAG_RESET;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function bit in_quiet_stretch();
      return accepted_requests >= QUIET_FIRST && accepted_requests < QUIET_LAST;
   endfunction

   // Give up on a hung run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // Response side: check each beat, stall at random, hold off once for a long stretch
   initial begin
      int unsigned hold_left;
      bit          held_once;
      hold_left = 0;
      held_once = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            outcome_board.check_response(rsp_bus.header_match, rsp_bus.frame_good,
                                         rsp_bus.read_byte);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!held_once && accepted_requests >= HOLD_OFF_START) begin
            held_once = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= in_quiet_stretch() || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Offer one request beat and hold it until accepted
   task automatic send_request(input logic op, input byte_type rx, input byte_type idx);
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= op;
      req_bus.rx_byte    <= rx;
      req_bus.read_index <= idx;
      do @(posedge clock); while (!req_bus.ready);
      outcome_board.note_request(op, rx, idx);
      accepted_requests++;
   endtask

   task automatic pause_requests(input int unsigned cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic offer_item(input logic op, input byte_type rx, input byte_type idx);
      if (!in_quiet_stretch() && $urandom_range(99) < IDLE_PERCENT)
         pause_requests($urandom_range(1, 5));
      send_request(op, rx, idx);
   endtask

   task automatic offer_receive(input byte_type rx);
      offer_item(OP_RECEIVE, rx, byte_type'($urandom_range(0, 255)));
   endtask

   task automatic offer_read(input byte_type idx);
      offer_item(OP_READ, byte_type'($urandom_range(0, 255)), idx);
   endtask

   // Mostly in-range record reads, now and then past the end
   task automatic offer_random_read();
      if ($urandom_range(15) == 0)
         offer_read(byte_type'($urandom_range(RECORD_LENGTH, 255)));
      else
         offer_read(byte_type'($urandom_range(0, RECORD_LENGTH - 1)));
   endtask

   // Drop valid, drain every expected response, then let the record walk finish
   task automatic wait_until_idle();
      req_bus.valid <= 1'b0;
      while (outcome_board.pending_count() != 0) @(posedge clock);
      repeat (RECORD_LENGTH + 20) @(posedge clock);
   endtask

   // Offer one register beat, then drop valid before returning
   task automatic write_register(input csr_index_type index, input byte_type data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      outcome_board.note_register_write(index, data);
      if (index == CSR_FRAME_MARKER) current_marker = data;
      if (index == CSR_TAG_BYTE) current_tag = data;
      @(posedge clock);
   endtask

   // Build a frame with correct markers and check bytes, optionally spoil one byte
   task automatic send_frame(input bit spoil);
      byte_type    body[RECORD_LENGTH];
      byte_type    xor_sum;
      byte_type    add_sum;
      int          p;
      int unsigned hit;
      for (p = 0; p < RECORD_LENGTH; p++) body[p] = byte_type'($urandom_range(0, 255));
      body[0]                 = current_marker;
      body[4]                 = current_tag;
      body[RECORD_LENGTH - 2] = current_marker;
      xor_sum = '0;
      add_sum = '0;
      for (p = 2; p < RECORD_LENGTH - 4; p++) begin
         xor_sum = xor_sum ^ body[p];
         add_sum = add_sum + body[p];
      end
      body[RECORD_LENGTH - 4] = xor_sum;
      body[RECORD_LENGTH - 3] = add_sum;
      if (spoil) begin
         hit = $urandom_range(0, RECORD_LENGTH - 1);
         body[hit] = body[hit] ^ byte_type'($urandom_range(1, 255));
      end
      // Slip the odd read in between bytes; reads leave the window alone
      for (p = 0; p < RECORD_LENGTH; p++) begin
         if ($urandom_range(99) < 5) offer_random_read();
         offer_receive(body[p]);
      end
   endtask

   initial begin
      int unsigned phase;
      int unsigned phase_end;
      int unsigned pick;
      int unsigned n;
      outcome_board = new();
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.operation  <= OP_RECEIVE;
      req_bus.rx_byte    <= '0;
      req_bus.read_index <= '0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= CSR_FRAME_MARKER;
      csr_bus.data       <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reads of the cleared store, including unwritten and out-of-range indexes
      offer_read(8'd0);
      offer_read(8'd1);
      offer_read(byte_type'(RECORD_LENGTH - 1));
      offer_read(byte_type'(RECORD_LENGTH));
      offer_read(8'hFF);
      // Receive extremes against the reset registers
      offer_receive(8'h00);
      offer_receive(8'hFF);
      offer_receive(TAG_RESET);
      wait_until_idle();

      // Zero marker and tag: the window still holding reset zeros matches
      write_register(CSR_FRAME_MARKER, 8'h00);
      write_register(CSR_TAG_BYTE, 8'h00);
      repeat (5) offer_receive(8'h00);
      offer_read(8'd2);
      offer_read(8'd3);
      offer_read(8'd1);
      offer_read(byte_type'(RECORD_LENGTH - 1));
      offer_receive(8'h80);
      wait_until_idle();

      // Writes to unmapped indexes must leave both registers as they are
      write_register(CSR_UNMAPPED_LOW, 8'hAA);
      write_register(CSR_UNMAPPED_TOP, 8'h55);
      offer_receive(8'h00);
      offer_read(8'd2);
      wait_until_idle();

      // Random phases, each under its own register setting
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               write_register(CSR_FRAME_MARKER, MARKER_RESET);
               write_register(CSR_TAG_BYTE, TAG_RESET);
            end
            1: begin
               write_register(CSR_FRAME_MARKER, 8'hFF);
               write_register(CSR_TAG_BYTE, 8'hFF);
            end
            2: begin
               write_register(CSR_FRAME_MARKER, 8'h00);
               write_register(CSR_TAG_BYTE, 8'hFF);
            end
            3: begin
               write_register(CSR_FRAME_MARKER, 8'hFF);
               write_register(CSR_TAG_BYTE, 8'h00);
            end
            default: begin
               write_register(CSR_FRAME_MARKER, byte_type'($urandom_range(0, 255)));
               write_register(CSR_TAG_BYTE, byte_type'($urandom_range(0, 255)));
               write_register(csr_index_type'($urandom_range(CSR_UNMAPPED_LOW, CSR_UNMAPPED_TOP)),
                              byte_type'($urandom_range(0, 255)));
            end
         endcase
         phase_end = accepted_requests + PHASE_ITEMS;
         while (accepted_requests < phase_end) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
               send_frame(1'b0);
            end else if (pick < 65) begin
               send_frame(1'b1);
            end else if (pick < 85) begin
               n = $urandom_range(1, 20);
               repeat (n) offer_receive(byte_type'($urandom_range(0, 255)));
            end else begin
               n = $urandom_range(1, 8);
               repeat (n) offer_random_read();
            end
         end
         wait_until_idle();
      end

      if (outcome_board.error_count == 0 && outcome_board.pending_count() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
design/sfc_pkg.sv
design/sfc_if.sv
design/sfc_mem.sv
design/sliding_frame_checker_unit.sv
sim/tb.sv
